>>> rtl/sqtm_pkg.sv
// ----------------------------------------------------------------------------
// Squarified treemap layout package
// Transfer types, arithmetic widths and constants shared by the layout block.
// ----------------------------------------------------------------------------
`default_nettype none

package sqtm_pkg;

  localparam int WEIGHT_W = 32;
  localparam int TOTAL_W  = 40;
  localparam int COORD_W  = 24;
  localparam int SLOT_W   = 5;
  localparam int NUM_W    = 128;
  localparam int Q_W      = 64;
  localparam int PHI_W    = 33;

  // Golden ratio in unsigned Q1.32, rounded to nearest.
  localparam logic [PHI_W-1:0] PHI_Q32 = 33'd6949403065;
  localparam logic [Q_W-1:0]   Q_INF   = '1;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_START = 1'b1;

  typedef struct packed {
    logic                action;
    logic [WEIGHT_W-1:0] child_value;
    logic [TOTAL_W-1:0]  total_value;
    logic [COORD_W-1:0]  rect_left;
    logic [COORD_W-1:0]  rect_top;
    logic [COORD_W-1:0]  rect_right;
    logic [COORD_W-1:0]  rect_bottom;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  child_slot;
    logic [COORD_W-1:0] out_left;
    logic [COORD_W-1:0] out_top;
    logic [COORD_W-1:0] out_right;
    logic [COORD_W-1:0] out_bottom;
    logic               last;
  } out_t;

endpackage

`default_nettype wire

>>> rtl/sqtm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sqtm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/sqtm_div.sv
// ----------------------------------------------------------------------------
// Saturating divider
// Restoring division, one quotient bit per cycle. A zero divisor or a
// quotient that does not fit in 64 bits gives all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module sqtm_div
  import sqtm_pkg::*;
#(
  parameter int DEN_W = 80
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   quot
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [Q_W-1:0]   low_r;
  logic [Q_W-1:0]   quot_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign trial = {rem_r, low_r[Q_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        den_r <= den;
        if (den == '0 || DEN_W'(num[NUM_W-1:Q_W]) >= den) begin
          quot_r <= Q_INF;
          done_r <= 1'b1;
        end else begin
          rem_r  <= DEN_W'(num[NUM_W-1:Q_W]);
          low_r  <= num[Q_W-1:0];
          quot_r <= '0;
          cnt_r  <= CNT_W'(Q_W);
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        low_r  <= {low_r[Q_W-2:0], 1'b0};
        quot_r <= {quot_r[Q_W-2:0], fits};
        cnt_r  <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

`default_nettype wire

>>> rtl/squarified_treemap_layout.sv
// ----------------------------------------------------------------------------
// Squarified treemap layout
// Stores child weights, then cuts the parent rectangle into strips whose
// rows grow while the worst golden-ratio aspect does not get worse.
// ----------------------------------------------------------------------------
//
//   Channel  Signals                       Moves
//   in       in_valid, in_ready, in_data   one load or start transfer
//   out      out_valid, out_ready, out_data one child rectangle per transfer
//
// A start runs the layout over the stored weights. Each aspect evaluation
// makes up to four passes through the one-bit-per-cycle divider and up to
// five multiplies.
// No clearing pass follows reset. The sequencer holds while a result waits.
`default_nettype none

module squarified_treemap_layout
  import sqtm_pkg::*;
#(
  parameter int MAX_CHILDREN = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int ADDR_W = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
  localparam int CNT_W  = $clog2(MAX_CHILDREN + 1);
  localparam int SUM_W  = WEIGHT_W + ADDR_W;
  localparam int SS_W   = 2 * SUM_W;
  localparam int DEN_W  = (SS_W > 72) ? SS_W : 72;

  typedef enum logic [5:0] {
    S_IDLE, S_ROW, S_ROW_PHI, S_FIRST_WAIT, S_FIRST_CHK, S_BEST,
    S_GROW_TEST, S_GROW_WAIT, S_GROW_CMP,
    S_R_SS, S_R_MNV, S_R_Q1, S_R_Q1D, S_R_R2, S_R_R2D, S_R_MXV, S_R_Q2,
    S_R_Q2D, S_R_R1, S_R_R1D, S_R_END,
    S_EDGE, S_EDGE_DIV, S_EDGE_SET,
    S_EMIT_INIT, S_EMIT_WAIT, S_EMIT_CUM, S_EMIT_DIV, S_EMIT_B, S_EMIT_OUT,
    S_EMIT_HOLD, S_ROW_NEXT, S_MUL, S_DIV
  } state_t;

  state_t state_r, sub_ret_r, ratio_ret_r;

  logic [CNT_W-1:0]   cnt_r, n_r, i0_r, i1_r, j_r;
  logic [COORD_W-1:0] x0_r, y0_r, x1_r, y1_r, dx_r, dy_r, lng_r;
  logic               across_r, sel_emit_r;
  logic [TOTAL_W-1:0] v_r;
  logic [SUM_W-1:0]   s_r, rs_r, cum_r;
  logic [WEIGHT_W-1:0] mx_r, mn_r, rmx_r, rmn_r;
  logic [Q_W-1:0]     shtphi_r, r1_r, r2_r, ratio_r, best_r;
  logic [SS_W-1:0]    ss_r;
  logic [COORD_W-1:0] edge_r, a_r, b_r;
  logic [63:0]        mul_a_r, mul_b_r, pp_r;
  logic [2:0]         mcnt_r;
  logic [1:0]         pp_sh_r;
  logic [NUM_W-1:0]   acc_r;
  logic               div_go_r;
  logic [NUM_W-1:0]   div_num_r;
  logic [DEN_W-1:0]   div_den_r;
  logic               out_valid_r;
  out_t               out_data_r;

  logic                ram_we;
  logic [ADDR_W-1:0]   rd_addr;
  logic [WEIGHT_W-1:0] rd_data;
  logic                div_done;
  logic [Q_W-1:0]      div_q;
  logic [31:0]         a_half, b_half;
  logic [63:0]         pp_nxt;
  logic [NUM_W-1:0]    pp_shifted;
  logic [COORD_W-1:0]  dx_c, dy_c, sht_c, len_c, base_c, far_c, near_c, d_c;
  logic [CNT_W-1:0]    i1_inc, j_inc;
  logic [SUM_W-1:0]    cum_nxt;
  logic [WEIGHT_W-1:0] nmn_c, nmx_c;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ram_we  = in_valid && in_ready && (in_data.action == ACT_LOAD) &&
                   (cnt_r < CNT_W'(MAX_CHILDREN));
  assign rd_addr = sel_emit_r ? j_r[ADDR_W-1:0] : i1_r[ADDR_W-1:0];

  sqtm_ram #(
    .WIDTH(WEIGHT_W),
    .DEPTH(MAX_CHILDREN)
  ) u_weight_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cnt_r[ADDR_W-1:0]),
    .wdata(in_data.child_value),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  sqtm_div #(
    .DEN_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go_r),
    .num  (div_num_r),
    .den  (div_den_r),
    .done (div_done),
    .quot (div_q)
  );

  assign a_half = mcnt_r[1] ? mul_a_r[63:32] : mul_a_r[31:0];
  assign b_half = mcnt_r[0] ? mul_b_r[63:32] : mul_b_r[31:0];
  assign pp_nxt = {32'b0, a_half} * {32'b0, b_half};

  always_comb begin
    case (pp_sh_r)
      2'd0:    pp_shifted = {64'b0, pp_r};
      2'd1:    pp_shifted = {32'b0, pp_r, 32'b0};
      default: pp_shifted = {pp_r, 64'b0};
    endcase
  end

  assign dx_c    = x1_r - x0_r;
  assign dy_c    = y1_r - y0_r;
  assign sht_c   = (dx_c > dy_c) ? dy_c : dx_c;
  assign len_c   = across_r ? dx_r : dy_r;
  assign base_c  = across_r ? x0_r : y0_r;
  assign far_c   = across_r ? y1_r : x1_r;
  assign near_c  = across_r ? y0_r : x0_r;
  assign d_c     = across_r ? dy_r : dx_r;
  assign i1_inc  = i1_r + CNT_W'(1);
  assign j_inc   = j_r + CNT_W'(1);
  assign cum_nxt = cum_r + SUM_W'(rd_data);
  assign nmn_c   = (rd_data < mn_r) ? rd_data : mn_r;
  assign nmx_c   = (rd_data > mx_r) ? rd_data : mx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sub_ret_r   <= S_IDLE;
      ratio_ret_r <= S_IDLE;
      cnt_r       <= '0;
      sel_emit_r  <= 1'b0;
      div_go_r    <= 1'b0;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.action == ACT_LOAD) begin
              if (cnt_r < CNT_W'(MAX_CHILDREN)) begin
                cnt_r <= cnt_r + CNT_W'(1);
              end
            end else begin
              v_r  <= in_data.total_value;
              x0_r <= in_data.rect_left;
              y0_r <= in_data.rect_top;
              x1_r <= (in_data.rect_right < in_data.rect_left) ?
                      in_data.rect_left : in_data.rect_right;
              y1_r <= (in_data.rect_bottom < in_data.rect_top) ?
                      in_data.rect_top : in_data.rect_bottom;
              n_r  <= cnt_r;
              i0_r <= '0;
              sel_emit_r <= 1'b0;
              if (cnt_r != '0) begin
                state_r <= S_ROW;
              end
            end
          end
        end
        S_ROW: begin
          dx_r     <= dx_c;
          dy_r     <= dy_c;
          lng_r    <= (dx_c > dy_c) ? dx_c : dy_c;
          across_r <= dx_c < dy_c;
          i1_r     <= i0_r;
          mul_a_r   <= 64'(sht_c);
          mul_b_r   <= 64'(PHI_Q32);
          mcnt_r    <= '0;
          acc_r     <= '0;
          sub_ret_r <= S_ROW_PHI;
          state_r   <= S_MUL;
        end
        S_ROW_PHI: begin
          shtphi_r <= acc_r[Q_W-1:0];
          state_r  <= S_FIRST_WAIT;
        end
        S_FIRST_WAIT: begin
          state_r <= S_FIRST_CHK;
        end
        S_FIRST_CHK: begin
          s_r   <= SUM_W'(rd_data);
          rs_r  <= SUM_W'(rd_data);
          mx_r  <= rd_data;
          mn_r  <= rd_data;
          rmx_r <= rd_data;
          rmn_r <= rd_data;
          i1_r  <= i1_inc;
          if (rd_data == '0 && i1_inc < n_r) begin
            state_r <= S_FIRST_WAIT;
          end else begin
            ratio_ret_r <= S_BEST;
            state_r     <= S_R_SS;
          end
        end
        S_BEST: begin
          best_r  <= ratio_r;
          state_r <= S_GROW_TEST;
        end
        S_GROW_TEST: begin
          if (i1_r < n_r) begin
            rs_r        <= s_r + SUM_W'(rd_data);
            rmn_r       <= nmn_c;
            rmx_r       <= nmx_c;
            ratio_ret_r <= S_GROW_CMP;
            state_r     <= S_R_SS;
          end else begin
            state_r <= S_EDGE;
          end
        end
        S_GROW_WAIT: begin
          state_r <= S_GROW_TEST;
        end
        S_GROW_CMP: begin
          if (ratio_r > best_r) begin
            state_r <= S_EDGE;
          end else begin
            s_r     <= rs_r;
            mn_r    <= rmn_r;
            mx_r    <= rmx_r;
            best_r  <= ratio_r;
            i1_r    <= i1_inc;
            state_r <= S_GROW_WAIT;
          end
        end
        S_R_SS: begin
          mul_a_r   <= 64'(rs_r);
          mul_b_r   <= 64'(rs_r);
          mcnt_r    <= '0;
          acc_r     <= '0;
          sub_ret_r <= S_R_MNV;
          state_r   <= S_MUL;
        end
        S_R_MNV: begin
          ss_r      <= acc_r[SS_W-1:0];
          mul_a_r   <= 64'(rmn_r);
          mul_b_r   <= 64'(v_r);
          mcnt_r    <= '0;
          acc_r     <= '0;
          sub_ret_r <= S_R_Q1;
          state_r   <= S_MUL;
        end
        S_R_Q1: begin
          div_num_r <= NUM_W'(ss_r) << 32;
          div_den_r <= acc_r[DEN_W-1:0];
          div_go_r  <= 1'b1;
          sub_ret_r <= S_R_Q1D;
          state_r   <= S_DIV;
        end
        S_R_Q1D: begin
          if (div_q == Q_INF) begin
            r2_r    <= Q_INF;
            state_r <= S_R_MXV;
          end else begin
            mul_a_r   <= div_q;
            mul_b_r   <= 64'(lng_r);
            mcnt_r    <= '0;
            acc_r     <= '0;
            sub_ret_r <= S_R_R2;
            state_r   <= S_MUL;
          end
        end
        S_R_R2: begin
          div_num_r <= acc_r << 32;
          div_den_r <= DEN_W'(shtphi_r);
          div_go_r  <= 1'b1;
          sub_ret_r <= S_R_R2D;
          state_r   <= S_DIV;
        end
        S_R_R2D: begin
          r2_r    <= div_q;
          state_r <= S_R_MXV;
        end
        S_R_MXV: begin
          mul_a_r   <= 64'(rmx_r);
          mul_b_r   <= 64'(v_r);
          mcnt_r    <= '0;
          acc_r     <= '0;
          sub_ret_r <= S_R_Q2;
          state_r   <= S_MUL;
        end
        S_R_Q2: begin
          div_num_r <= acc_r << 32;
          div_den_r <= DEN_W'(ss_r);
          div_go_r  <= 1'b1;
          sub_ret_r <= S_R_Q2D;
          state_r   <= S_DIV;
        end
        S_R_Q2D: begin
          if (div_q == Q_INF) begin
            r1_r    <= Q_INF;
            state_r <= S_R_END;
          end else begin
            mul_a_r   <= div_q;
            mul_b_r   <= shtphi_r;
            mcnt_r    <= '0;
            acc_r     <= '0;
            sub_ret_r <= S_R_R1;
            state_r   <= S_MUL;
          end
        end
        S_R_R1: begin
          div_num_r <= acc_r;
          div_den_r <= DEN_W'({lng_r, 32'b0});
          div_go_r  <= 1'b1;
          sub_ret_r <= S_R_R1D;
          state_r   <= S_DIV;
        end
        S_R_R1D: begin
          r1_r    <= div_q;
          state_r <= S_R_END;
        end
        S_R_END: begin
          ratio_r <= (r1_r > r2_r) ? r1_r : r2_r;
          state_r <= ratio_ret_r;
        end
        S_EDGE: begin
          if (v_r == '0) begin
            edge_r  <= far_c;
            state_r <= S_EMIT_INIT;
          end else begin
            mul_a_r   <= 64'(d_c);
            mul_b_r   <= 64'(s_r);
            mcnt_r    <= '0;
            acc_r     <= '0;
            sub_ret_r <= S_EDGE_DIV;
            state_r   <= S_MUL;
          end
        end
        S_EDGE_DIV: begin
          div_num_r <= acc_r;
          div_den_r <= DEN_W'(v_r);
          div_go_r  <= 1'b1;
          sub_ret_r <= S_EDGE_SET;
          state_r   <= S_DIV;
        end
        S_EDGE_SET: begin
          if (div_q < 64'(d_c)) begin
            edge_r <= near_c + div_q[COORD_W-1:0];
          end else begin
            edge_r <= far_c;
          end
          state_r <= S_EMIT_INIT;
        end
        S_EMIT_INIT: begin
          j_r        <= i0_r;
          cum_r      <= '0;
          a_r        <= base_c;
          sel_emit_r <= 1'b1;
          state_r    <= S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          state_r <= S_EMIT_CUM;
        end
        S_EMIT_CUM: begin
          cum_r <= cum_nxt;
          if (s_r == '0) begin
            b_r     <= base_c;
            state_r <= S_EMIT_OUT;
          end else begin
            mul_a_r   <= 64'(len_c);
            mul_b_r   <= 64'(cum_nxt);
            mcnt_r    <= '0;
            acc_r     <= '0;
            sub_ret_r <= S_EMIT_DIV;
            state_r   <= S_MUL;
          end
        end
        S_EMIT_DIV: begin
          div_num_r <= acc_r;
          div_den_r <= DEN_W'(s_r);
          div_go_r  <= 1'b1;
          sub_ret_r <= S_EMIT_B;
          state_r   <= S_DIV;
        end
        S_EMIT_B: begin
          b_r     <= base_c + div_q[COORD_W-1:0];
          state_r <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          out_valid_r           <= 1'b1;
          out_data_r.child_slot <= SLOT_W'(j_r);
          out_data_r.last       <= (j_inc == n_r);
          if (across_r) begin
            out_data_r.out_left   <= a_r;
            out_data_r.out_top    <= y0_r;
            out_data_r.out_right  <= b_r;
            out_data_r.out_bottom <= edge_r;
          end else begin
            out_data_r.out_left   <= x0_r;
            out_data_r.out_top    <= a_r;
            out_data_r.out_right  <= edge_r;
            out_data_r.out_bottom <= b_r;
          end
          state_r <= S_EMIT_HOLD;
        end
        S_EMIT_HOLD: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            a_r         <= b_r;
            j_r         <= j_inc;
            state_r     <= (j_inc < i1_r) ? S_EMIT_WAIT : S_ROW_NEXT;
          end
        end
        S_ROW_NEXT: begin
          if (across_r) begin
            y0_r <= edge_r;
          end else begin
            x0_r <= edge_r;
          end
          v_r        <= (v_r > TOTAL_W'(s_r)) ? v_r - TOTAL_W'(s_r) : '0;
          i0_r       <= i1_r;
          sel_emit_r <= 1'b0;
          if (i1_r < n_r) begin
            state_r <= S_ROW;
          end else begin
            cnt_r   <= '0;
            state_r <= S_IDLE;
          end
        end
        S_MUL: begin
          if (mcnt_r != 3'd4) begin
            pp_r    <= pp_nxt;
            pp_sh_r <= {1'b0, mcnt_r[1]} + {1'b0, mcnt_r[0]};
          end
          if (mcnt_r != 3'd0) begin
            acc_r <= acc_r + pp_shifted;
          end
          mcnt_r <= mcnt_r + 3'd1;
          if (mcnt_r == 3'd4) begin
            state_r <= sub_ret_r;
          end
        end
        S_DIV: begin
          div_go_r <= 1'b0;
          if (div_done) begin
            state_r <= sub_ret_r;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_no_load_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input accepted while a result is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_CHILDREN))
    else $error("load count beyond capacity");

  a_emit_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_HOLD) |-> (j_r < i1_r && i1_r <= n_r))
    else $error("emitted child outside the current row");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last) |-> ##2 (state_r == S_IDLE))
    else $error("layout did not finish after the last rectangle");

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Squarified treemap layout testbench
// Loads child weights and starts layouts through the input channel, predicts
// every child rectangle with a bit-accurate software layout and checks each
// transfer on the result channel, under several idle and stall patterns.
// ----------------------------------------------------------------------------

module tb_top;
  import sqtm_pkg::*;

  class layout_scoreboard;
    logic [WEIGHT_W-1:0] weights [32];
    int unsigned loaded;
    out_t rects_due [$];
    int errors;

    function logic [63:0] div_sat(logic [127:0] num, logic [127:0] den);
      logic [127:0] q;
      if (den == 0) return Q_INF;
      q = num / den;
      if (q[127:64] != 0) return Q_INF;
      return q[63:0];
    endfunction

    function logic [63:0] worst_aspect(logic [63:0] s, logic [63:0] mx, logic [63:0] mn,
                                       logic [63:0] v, logic [63:0] lng, logic [63:0] sht);
      logic [63:0] q, r1, r2, sp;
      logic [127:0] num;
      num = (128'(s) * 128'(s)) << 32;
      q = div_sat(num, 128'(mn) * 128'(v));
      r2 = (q == Q_INF) ? Q_INF :
           div_sat((128'(q) * 128'(lng)) << 32, 128'(sht) * 128'(PHI_Q32));
      q = div_sat((128'(mx) * 128'(v)) << 32, 128'(s) * 128'(s));
      sp = sht * 64'(PHI_Q32);
      r1 = (q == Q_INF) ? Q_INF : div_sat(128'(q) * 128'(sp), 128'(lng << 32));
      return (r1 > r2) ? r1 : r2;
    endfunction

    function void note_input(in_t d);
      logic [63:0] x0, y0, x1, y1, v, dx, dy, lng, sht, s, mx, mn, best;
      logic [63:0] w, ns, nmn, nmx, r, cum, edge_pos, len, base, a, b;
      int unsigned n, i0, i1, j;
      bit across;
      out_t o;
      if (d.action == ACT_LOAD) begin
        if (loaded < 32) begin
          weights[loaded] = d.child_value;
          loaded++;
        end
        return;
      end
      v = d.total_value;
      x0 = d.rect_left;
      y0 = d.rect_top;
      x1 = d.rect_right;
      y1 = d.rect_bottom;
      if (x1 < x0) x1 = x0;
      if (y1 < y0) y1 = y0;
      n = loaded;
      i0 = 0;
      while (i0 < n) begin
        dx = x1 - x0;
        dy = y1 - y0;
        lng = (dx > dy) ? dx : dy;
        sht = (dx > dy) ? dy : dx;
        across = dx < dy;
        i1 = i0;
        s = weights[i1];
        i1++;
        while (s == 0 && i1 < n) begin
          s = weights[i1];
          i1++;
        end
        mx = s;
        mn = s;
        best = worst_aspect(s, mx, mn, v, lng, sht);
        while (i1 < n) begin
          w = weights[i1];
          ns = s + w;
          nmn = (w < mn) ? w : mn;
          nmx = (w > mx) ? w : mx;
          r = worst_aspect(ns, nmx, nmn, v, lng, sht);
          if (r > best) break;
          s = ns;
          mn = nmn;
          mx = nmx;
          best = r;
          i1++;
        end
        if (across) begin
          edge_pos = y1;
          if (v != 0 && dy * s / v < dy) edge_pos = y0 + dy * s / v;
        end else begin
          edge_pos = x1;
          if (v != 0 && dx * s / v < dx) edge_pos = x0 + dx * s / v;
        end
        cum = 0;
        len = across ? dx : dy;
        base = across ? x0 : y0;
        for (j = i0; j < i1; j++) begin
          a = base + ((s != 0) ? len * cum / s : 0);
          cum += weights[j];
          b = base + ((s != 0) ? len * cum / s : 0);
          o.child_slot = j[4:0];
          if (across) begin
            o.out_left = a[23:0]; o.out_top = y0[23:0];
            o.out_right = b[23:0]; o.out_bottom = edge_pos[23:0];
          end else begin
            o.out_left = x0[23:0]; o.out_top = a[23:0];
            o.out_right = edge_pos[23:0]; o.out_bottom = b[23:0];
          end
          o.last = (j + 1 == n);
          rects_due.push_back(o);
        end
        if (across) y0 = edge_pos; else x0 = edge_pos;
        v = (v > s) ? v - s : 0;
        i0 = i1;
      end
      loaded = 0;
    endfunction

    function void field_check(string name, logic [23:0] exp_v, logic [23:0] got_v);
      if (exp_v !== got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      end
    endfunction

    function void check(out_t got);
      out_t e;
      if (rects_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected rectangle, expected none, actual %p", $time, got);
        return;
      end
      e = rects_due.pop_front();
      field_check("child_slot", e.child_slot, got.child_slot);
      field_check("out_left", e.out_left, got.out_left);
      field_check("out_top", e.out_top, got.out_top);
      field_check("out_right", e.out_right, got.out_right);
      field_check("out_bottom", e.out_bottom, got.out_bottom);
      field_check("last", e.last, got.last);
    endfunction
  endclass

  localparam int STALL_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  layout_scoreboard sb;
  int send_pct;
  int stall_pct;
  bit hold_req;
  int hold_left;
  int quiet_cycles;
  int sent;

  squarified_treemap_layout u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check(out_data);
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send(in_t d);
    bit done;
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    done = 1'b0;
    while (!done) begin
      @(posedge clk);
      done = in_ready;
    end
    sb.note_input(d);
    sent++;
    @(negedge clk);
  endtask

  task automatic load_weight(logic [31:0] w);
    in_t d;
    d = '0;
    d.action = ACT_LOAD;
    d.child_value = w;
    d.total_value = {$urandom, $urandom};
    d.rect_left = $urandom;
    d.rect_right = $urandom;
    send(d);
  endtask

  task automatic start_layout(logic [39:0] total, logic [23:0] l, logic [23:0] t,
                              logic [23:0] r, logic [23:0] b);
    in_t d;
    d.action = ACT_START;
    d.child_value = $urandom;
    d.total_value = total;
    d.rect_left = l;
    d.rect_top = t;
    d.rect_right = r;
    d.rect_bottom = b;
    send(d);
  endtask

  task automatic random_node(bit noisy);
    logic [31:0] ws [$];
    logic [39:0] sum;
    logic [39:0] total;
    logic [23:0] l, t, r, b;
    int n, k;
    n = ($urandom_range(9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 6);
    if (noisy && $urandom_range(3) == 0) n = $urandom_range(33, 34);
    sum = 0;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(3))
        0: ws.push_back($urandom);
        1: ws.push_back($urandom_range(0, 3));
        default: ws.push_back($urandom_range(1, 5000));
      endcase
    end
    if (!noisy) ws.rsort();
    foreach (ws[k]) sum += ws[k];
    total = noisy ? {$urandom, $urandom} : sum + $urandom_range(0, 100);
    if ($urandom_range(4) == 0) begin
      l = $urandom; t = $urandom; r = $urandom; b = $urandom;
    end else begin
      l = $urandom_range(0, 20000);
      t = $urandom_range(0, 20000);
      r = l + $urandom_range(0, 1 << $urandom_range(2, 22));
      b = t + $urandom_range(0, 1 << $urandom_range(2, 22));
    end
    foreach (ws[k]) load_weight(ws[k]);
    start_layout(total, l, t, r, b);
  endtask

  initial begin
    int phase;
    int first;
    sb = new();
    sb.loaded = 0;
    sb.errors = 0;
    send_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    quiet_cycles = 0;
    sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    start_layout(40'd100, 24'd0, 24'd0, 24'd1000, 24'd1000);
    load_weight(32'd0); load_weight(32'd0); load_weight(32'd5); load_weight(32'd3);
    start_layout(40'd8, 24'd100, 24'd200, 24'd5100, 24'd3200);
    load_weight(32'd0); load_weight(32'd0);
    start_layout(40'd0, 24'd0, 24'd0, 24'd800, 24'd400);
    load_weight(32'd4); load_weight(32'd2); load_weight(32'd1);
    start_layout(40'd0, 24'd10, 24'd10, 24'd300, 24'd900);
    load_weight(32'd4); load_weight(32'd2);
    start_layout(40'd3, 24'd0, 24'd0, 24'd640, 24'd480);
    load_weight(32'd7); load_weight(32'd7);
    start_layout(40'd14, 24'd500, 24'd0, 24'd500, 24'd4000);
    load_weight(32'hFFFF_FFFF); load_weight(32'd1);
    start_layout(40'hFF_FFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'd0, 24'd0);
    load_weight(32'hFFFF_FFFF); load_weight(32'd1);
    start_layout(40'h1_0000_0000, 24'd0, 24'd0, 24'hFF_FFFF, 24'hFF_FFFF);

    first = sent;
    while (sent < 125) begin
      phase = ((sent - first) * 5) / (125 - first);
      case (phase)
        0: begin send_pct = 0; stall_pct = 0; end
        1: begin send_pct = 66; stall_pct = 0; end
        2: begin send_pct = 0; stall_pct = 66; end
        3: begin send_pct = 32; stall_pct = 32; end
        default: begin send_pct = 0; stall_pct = 0; end
      endcase
      if (phase == 4 && sent < 120) hold_req = 1'b1;
      random_node($urandom_range(9) == 0);
    end
    in_valid <= 1'b0;

    while (sb.rects_due.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/sqtm_pkg.sv
rtl/sqtm_ram.sv
rtl/sqtm_div.sv
rtl/squarified_treemap_layout.sv
sim/tb_top.sv
